>>> hdl/wma_pkg.sv
// Package for the windowed moving average: field widths, parameter defaults,
// sequencer state and shared adder operation codes.
// No dependencies.
package wma_pkg;

    localparam int IN_BITS  = 48;
    localparam int OUT_BITS = 48;

    localparam int DEF_WINDOW_DEPTH = 16;
    localparam int DEF_SAMPLE_BITS  = 48;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB,
        ST_ADD,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

>>> hdl/windowed_moving_average.sv
// Windowed moving average with warm-up: sequencer, running sum and a restoring
// divider that shares one adder. Depends on wma_pkg, wma_ram, wma_alu.
// The divider's loop produces one quotient bit per cycle over SUM_BITS bits
// (SUM_BITS = stored sample width + log2 of window depth, 52 by default).
// A new sample word is taken only in the idle state, once the previous average
// has been taken with no output stall. Reset clears sum, index and full flag.
module windowed_moving_average #(
    parameter int WINDOW_DEPTH = wma_pkg::DEF_WINDOW_DEPTH,
    parameter int SAMPLE_BITS  = wma_pkg::DEF_SAMPLE_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  logic [wma_pkg::IN_BITS-1:0]  sample,
    output logic                         average_valid,
    input  logic                         average_stall,
    output logic [wma_pkg::OUT_BITS-1:0] average
);

    localparam int STORE_BITS = (SAMPLE_BITS < wma_pkg::IN_BITS) ? SAMPLE_BITS
                                                                 : wma_pkg::IN_BITS;
    localparam int IDX_BITS   = $clog2(WINDOW_DEPTH);
    localparam int SUM_BITS   = STORE_BITS + IDX_BITS;
    localparam int DIV_BITS   = $clog2(WINDOW_DEPTH + 1);
    localparam int CNT_BITS   = $clog2(SUM_BITS);

    wma_pkg::state_t state_reg, state_next;

    logic [IDX_BITS-1:0]   idx_reg, idx_next;
    logic                  full_reg, full_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [STORE_BITS-1:0] sample_reg, sample_next;
    logic [SUM_BITS-1:0]   quot_reg, quot_next;
    logic [DIV_BITS-1:0]   rem_reg, rem_next;
    logic [DIV_BITS-1:0]   divisor_reg, divisor_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;

    logic                  accept;
    logic                  ram_wr_en;
    logic                  ram_rd_en;
    logic [STORE_BITS-1:0] ram_rd_data;

    wma_pkg::alu_op_t      alu_op;
    logic [SUM_BITS-1:0]   alu_a;
    logic [SUM_BITS-1:0]   alu_b;
    logic [SUM_BITS-1:0]   alu_res;
    logic                  alu_borrow;
    logic [DIV_BITS:0]     trial;

    assign accept = sample_valid && !sample_stall;
    assign trial  = {rem_reg, quot_reg[SUM_BITS-1]};

    wma_ram #(
        .WIDTH (STORE_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_history (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (idx_reg),
        .wr_data (sample_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    wma_alu #(
        .WIDTH (SUM_BITS)
    ) u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_res),
        .borrow (alu_borrow)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wma_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = wma_pkg::ST_SUB;
                end
            end
            wma_pkg::ST_SUB: state_next = wma_pkg::ST_ADD;
            wma_pkg::ST_ADD: state_next = wma_pkg::ST_DIV;
            wma_pkg::ST_DIV:
            begin
                if (count_reg == CNT_BITS'(SUM_BITS - 1))
                begin
                    state_next = wma_pkg::ST_OUT;
                end
            end
            wma_pkg::ST_OUT:
            begin
                if (!average_stall)
                begin
                    state_next = wma_pkg::ST_IDLE;
                end
            end
            default: state_next = wma_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        sample_stall  = 1'b1;
        average_valid = 1'b0;
        ram_rd_en     = 1'b0;
        ram_wr_en     = 1'b0;
        alu_op        = wma_pkg::ALU_ADD;
        alu_a         = sum_reg;
        alu_b         = SUM_BITS'(sample_reg);
        unique case (state_reg)
            wma_pkg::ST_IDLE:
            begin
                sample_stall = 1'b0;
                ram_rd_en    = 1'b1;
            end
            wma_pkg::ST_SUB:
            begin
                // oldest entry leaves the sum only once the ring has wrapped
                ram_wr_en = 1'b1;
                alu_op    = wma_pkg::ALU_SUB;
                alu_b     = full_reg ? SUM_BITS'(ram_rd_data) : '0;
            end
            wma_pkg::ST_ADD:
            begin
                alu_op = wma_pkg::ALU_ADD;
            end
            wma_pkg::ST_DIV:
            begin
                alu_op = wma_pkg::ALU_SUB;
                alu_a  = SUM_BITS'(trial);
                alu_b  = SUM_BITS'(divisor_reg);
            end
            wma_pkg::ST_OUT:
            begin
                average_valid = 1'b1;
            end
            default:
            begin
                sample_stall = 1'b1;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        idx_next     = idx_reg;
        full_next    = full_reg;
        sum_next     = sum_reg;
        sample_next  = sample_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        count_next   = count_reg;
        unique case (state_reg)
            wma_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    sample_next = sample[STORE_BITS-1:0];
                end
            end
            wma_pkg::ST_SUB:
            begin
                sum_next = alu_res;
            end
            wma_pkg::ST_ADD:
            begin
                sum_next     = alu_res;
                quot_next    = alu_res;
                rem_next     = '0;
                count_next   = '0;
                divisor_next = full_reg ? DIV_BITS'(WINDOW_DEPTH)
                                        : DIV_BITS'(idx_reg) + DIV_BITS'(1);
                if (idx_reg == IDX_BITS'(WINDOW_DEPTH - 1))
                begin
                    idx_next  = '0;
                    full_next = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + IDX_BITS'(1);
                end
            end
            wma_pkg::ST_DIV:
            begin
                // restoring step: keep the difference when it does not borrow
                rem_next   = alu_borrow ? trial[DIV_BITS-1:0] : alu_res[DIV_BITS-1:0];
                quot_next  = {quot_reg[SUM_BITS-2:0], !alu_borrow};
                count_next = count_reg + CNT_BITS'(1);
            end
            wma_pkg::ST_OUT:
            begin
                quot_next = quot_reg;
            end
            default:
            begin
                quot_next = quot_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wma_pkg::ST_IDLE;
            idx_reg   <= '0;
            full_reg  <= 1'b0;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            full_reg  <= full_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign average = wma_pkg::OUT_BITS'(quot_reg);

endmodule

>>> hdl/wma_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module wma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/wma_alu.sv
// Shared add/subtract unit used for the running sum and each divide step.
// Depends on wma_pkg.
module wma_alu #(
    parameter int WIDTH = 8
) (
    input  wma_pkg::alu_op_t op,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] result,
    output logic             borrow
);

    logic [WIDTH:0] full_res;

    always_comb
    begin
        unique case (op)
            wma_pkg::ALU_ADD: full_res = {1'b0, a} + {1'b0, b};
            wma_pkg::ALU_SUB: full_res = {1'b0, a} - {1'b0, b};
        endcase
    end

    // top bit is carry on add, borrow on subtract
    assign result = full_res[WIDTH-1:0];
    assign borrow = full_res[WIDTH];

endmodule
